>>> design/sbms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbms_pkg
// Shared types and constants for the sparse bit matrix store.
// ----------------------------------------------------------------------------
package sbms_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned IdxW    = 12;
  localparam int unsigned GroupW  = 9;
  localparam int unsigned BitsW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned NumW    = 13;
  localparam int unsigned CountW  = 10;

  localparam logic [NumW-1:0]   NumReset = 13'd4096;
  localparam logic [CountW-1:0] CountMax = 10'd1023;

  localparam logic [ModeW-1:0] MODE_LOAD  = 2'd0;
  localparam logic [ModeW-1:0] MODE_QUERY = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR = 2'd2;

  localparam logic [StatusW-1:0] ST_OK    = 3'd0;
  localparam logic [StatusW-1:0] ST_DONE  = 3'd1;
  localparam logic [StatusW-1:0] ST_BELOW = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL  = 3'd3;
  localparam logic [StatusW-1:0] ST_RANGE = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LD_RD,
    S_LD_CHK,
    S_Q_RD,
    S_Q_CHK,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DONE
  } state_e;

endpackage

>>> design/sbms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbms_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sbms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sparse_bit_matrix_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_bit_matrix_store_unit
// Sparse symmetric bit matrix: per-column lists of nonzero byte groups in a
// shared pool, loaded one group per word and queried by binary search.
// Load reads the column table entry, then checks the group and writes it. Query
// reads the entry, then runs search steps of one read and one compare each,
// at most 10 steps for a 1023-entry column.
// Clear: every column table entry is swept, one entry per cycle.
// One word in flight at a time; the search loop shares one pool read port
// and one compare. After reset the column table is swept entry by entry
// before the first word is accepted.
// ----------------------------------------------------------------------------
module sparse_bit_matrix_store_unit import sbms_pkg::*; #(
  parameter int MAX_PATCHES  = 4096,
  parameter int POOL_ENTRIES = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [NumW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [IdxW-1:0]    column_i,
  input  logic [IdxW-1:0]    other_i,
  input  logic [GroupW-1:0]  group_i,
  input  logic [BitsW-1:0]   bits_i,
  input  logic               last_group_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               visible_o,
  output logic [StatusW-1:0] status_o
);

  localparam int PW   = $clog2(MAX_PATCHES);
  localparam int AW   = $clog2(POOL_ENTRIES);
  localparam int FW   = AW + 1;
  localparam int CEW  = 1 + CountW + AW;
  localparam int PEW  = GroupW + BitsW;
  localparam logic [PW-1:0] LastIdx = PW'(MAX_PATCHES - 1);

  state_e state_q, state_d;

  logic [NumW-1:0]    num_q;
  logic [IdxW-1:0]    x_q, y_q;
  logic [GroupW-1:0]  grp_q;
  logic [BitsW-1:0]   bits_q;
  logic               last_q;
  logic [StatusW-1:0] st_q, st_d;
  logic               vis_q, vis_d;
  logic               clr_item_q, clr_item_d;
  logic [PW-1:0]      clr_idx_q, clr_idx_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [AW-1:0]      base_q, base_d;
  logic [CountW-1:0]  lo_q, lo_d, hip_q, hip_d, mid_q, mid_d;
  logic               out_valid_q, out_valid_d;
  logic               out_vis_q, out_vis_d;
  logic [StatusW-1:0] out_st_q, out_st_d;

  logic               accept;
  logic [IdxW-1:0]    in_x, in_y;
  logic               in_x_exists, in_col_exists, in_y_exists;

  logic               col_we;
  logic [PW-1:0]      col_waddr, col_raddr;
  logic [CEW-1:0]     col_wdata, col_rdata;
  logic               pool_we;
  logic [AW-1:0]      pool_waddr, pool_raddr;
  logic [PEW-1:0]     pool_wdata, pool_rdata;

  logic               ent_done;
  logic [CountW-1:0]  ent_count;
  logic [AW-1:0]      ent_base;
  logic [GroupW-1:0]  pool_grp;
  logic [BitsW-1:0]   pool_bits;

  logic [BitsW-1:0]   mask;
  logic               below;
  logic [IdxW-1:0]    gp;
  logic [CountW:0]    mid_sum;
  logic [CountW-1:0]  mid_c;

  sbms_ram #(.Width(CEW), .Depth(MAX_PATCHES)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (col_wdata),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  sbms_ram #(.Width(PEW), .Depth(POOL_ENTRIES)) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .raddr_i (pool_raddr),
    .rdata_o (pool_rdata)
  );

  assign {ent_done, ent_count, ent_base} = col_rdata;
  assign {pool_grp, pool_bits}           = pool_rdata;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign visible_o   = out_vis_q;
  assign status_o    = out_st_q;

  assign in_x = (column_i < other_i) ? column_i : other_i;
  assign in_y = (column_i < other_i) ? other_i : column_i;
  assign in_col_exists = ({1'b0, column_i} < num_q) && (32'(column_i) < MAX_PATCHES);
  assign in_y_exists   = ({1'b0, in_y} < num_q) && (32'(in_y) < MAX_PATCHES);
  assign in_x_exists   = (32'(in_x) < MAX_PATCHES);

  // drop bits of missing patches, flag bits below the diagonal
  always_comb begin
    mask  = '0;
    below = 1'b0;
    gp    = '0;
    for (int k = 0; k < BitsW; k++) begin
      gp = {grp_q, 3'(k)};
      mask[k] = bits_q[k] && ({1'b0, gp} < num_q) && (32'(gp) < MAX_PATCHES);
      if (mask[k] && (gp < x_q)) begin
        below = 1'b1;
      end
    end
  end

  assign mid_sum = {1'b0, lo_q} + {1'b0, hip_q} - 11'd1;
  assign mid_c   = mid_sum[CountW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      num_q       <= NumReset;
      clr_item_q  <= 1'b0;
      clr_idx_q   <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_item_q  <= clr_item_d;
      clr_idx_q   <= clr_idx_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      grp_q  <= group_i;
      bits_q <= bits_i;
      last_q <= last_group_i;
      x_q    <= (mode_i == MODE_QUERY) ? in_x : column_i;
      y_q    <= in_y;
    end
    st_q      <= st_d;
    vis_q     <= vis_d;
    base_q    <= base_d;
    lo_q      <= lo_d;
    hip_q     <= hip_d;
    mid_q     <= mid_d;
    out_vis_q <= out_vis_d;
    out_st_q  <= out_st_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_item_d  = clr_item_q;
    clr_idx_d   = clr_idx_q;
    fill_d      = fill_q;
    st_d        = st_q;
    vis_d       = vis_q;
    base_d      = base_q;
    lo_d        = lo_q;
    hip_d       = hip_q;
    mid_d       = mid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_vis_d   = out_vis_q;
    out_st_d    = out_st_q;
    col_we      = 1'b0;
    col_waddr   = PW'(x_q);
    col_wdata   = {ent_done, ent_count, ent_base};
    col_raddr   = PW'(x_q);
    pool_we     = 1'b0;
    pool_waddr  = AW'(fill_q);
    pool_wdata  = {grp_q, mask};
    pool_raddr  = base_q + AW'(mid_c);

    unique case (state_q)
      S_CLEAR: begin
        col_we    = 1'b1;
        col_waddr = clr_idx_q;
        col_wdata = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == LastIdx) begin
          clr_idx_d = '0;
          if (clr_item_q) begin
            st_d    = ST_OK;
            vis_d   = 1'b0;
            state_d = S_DONE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          vis_d = 1'b0;
          st_d  = ST_OK;
          unique case (mode_i)
            MODE_LOAD: begin
              if (in_col_exists) begin
                state_d = S_LD_RD;
              end else begin
                st_d    = ST_RANGE;
                state_d = S_DONE;
              end
            end
            MODE_QUERY: begin
              if (column_i == other_i) begin
                vis_d   = 1'b1;
                state_d = S_DONE;
              end else begin
                st_d    = in_y_exists ? ST_OK : ST_RANGE;
                state_d = in_x_exists ? S_Q_RD : S_DONE;
              end
            end
            MODE_CLEAR: begin
              fill_d     = '0;
              clr_item_d = 1'b1;
              clr_idx_d  = '0;
              state_d    = S_CLEAR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_LD_RD: begin
        state_d = S_LD_CHK;
      end
      S_LD_CHK: begin
        state_d = S_DONE;
        if (ent_done) begin
          st_d = ST_DONE;
        end else if (below) begin
          st_d = ST_BELOW;
        end else if (mask != '0) begin
          if ((32'(fill_q) >= POOL_ENTRIES) || (ent_count >= CountMax)) begin
            st_d = ST_FULL;
          end else begin
            pool_we   = 1'b1;
            fill_d    = fill_q + 1'b1;
            col_we    = 1'b1;
            col_wdata = {last_q, ent_count + 1'b1,
                         (ent_count == '0) ? AW'(fill_q) : ent_base};
          end
        end else if (last_q) begin
          col_we    = 1'b1;
          col_wdata = {1'b1, ent_count, ent_base};
        end
      end
      S_Q_RD: begin
        state_d = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (ent_count == '0) begin
          vis_d   = 1'b0;
          state_d = S_DONE;
        end else begin
          base_d  = ent_base;
          lo_d    = '0;
          hip_d   = ent_count;
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (lo_q < hip_q) begin
          mid_d   = mid_c;
          state_d = S_SRCH_CMP;
        end else begin
          vis_d   = 1'b0;
          state_d = S_DONE;
        end
      end
      S_SRCH_CMP: begin
        if (pool_grp < y_q[IdxW-1:3]) begin
          lo_d    = mid_q + 1'b1;
          state_d = S_SRCH_RD;
        end else if (pool_grp > y_q[IdxW-1:3]) begin
          hip_d   = mid_q;
          state_d = S_SRCH_RD;
        end else begin
          vis_d   = pool_bits[y_q[2:0]];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_vis_d   = vis_q;
          out_st_d    = st_q;
          clr_item_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> verif/tb_sparse_bit_matrix_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_bit_matrix_store_unit
// Self-checking bench for the sparse bit matrix store. A behavioral copy of
// the matrix (column table, group pool, fill pointer) predicts visible and
// status for every accepted word. Results are compared in order, field by
// field. Directed words cover load rules, query rules and patch count
// limits. A long column pass loads one column with many groups and runs
// deep searches on it. Random traffic follows, mostly well-formed column
// loads and queries on loaded columns, under several patch counts, with
// random stalls on both handshakes.
// ----------------------------------------------------------------------------
module tb_sparse_bit_matrix_store_unit;
  import sbms_pkg::*;

  localparam int MaxPatches  = 4096;
  localparam int PoolEntries = 16384;
  localparam int MaxWait     = 12;
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 40;
  localparam int PhaseWords  = 120;
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  typedef struct {
    logic [ModeW-1:0]   mode;
    logic [IdxW-1:0]    a;
    logic [IdxW-1:0]    b;
    logic               visible;
    logic [StatusW-1:0] status;
  } answer_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [NumW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [ModeW-1:0]   mode_i;
  logic [IdxW-1:0]    column_i;
  logic [IdxW-1:0]    other_i;
  logic [GroupW-1:0]  group_i;
  logic [BitsW-1:0]   bits_i;
  logic               last_group_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               visible_o;
  logic [StatusW-1:0] status_o;

  // matrix copy
  int unsigned     patch_limit;
  int unsigned     col_start [MaxPatches];
  int unsigned     col_len [MaxPatches];
  bit              col_closed [MaxPatches];
  int unsigned     pool_grp [PoolEntries];
  logic [BitsW-1:0] pool_mask [PoolEntries];
  int unsigned     pool_used;

  answer_t     pending_answers[$];
  answer_t     head_answer;
  int unsigned filled_cols[$];
  bit          in_idle_on;
  bit          out_idle_on;
  int          ready_hold;
  int          cycle_count;
  int          mismatches;
  int          words_sent;
  int          results_seen;
  int          settings_used;

  sparse_bit_matrix_store_unit #(
    .MAX_PATCHES (MaxPatches),
    .POOL_ENTRIES(PoolEntries)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .column_i    (column_i),
    .other_i     (other_i),
    .group_i     (group_i),
    .bits_i      (bits_i),
    .last_group_i(last_group_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .visible_o   (visible_o),
    .status_o    (status_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit patch_present(input int unsigned p);
    return p < patch_limit && p < MaxPatches;
  endfunction

  function automatic void clear_matrix_copy();
    for (int i = 0; i < MaxPatches; i++) begin
      col_len[i] = 0;
      col_closed[i] = 1'b0;
    end
    pool_used = 0;
  endfunction

  function automatic logic [StatusW-1:0] load_column_group(input int unsigned c,
      input int unsigned grp, input logic [BitsW-1:0] raw, input logic last);
    logic [BitsW-1:0] kept;
    int unsigned p;
    kept = '0;
    if (!patch_present(c)) return ST_RANGE;
    if (col_closed[c]) return ST_DONE;
    for (int k = 0; k < BitsW; k++) begin
      p = grp * 8 + k;
      if (raw[k] && patch_present(p)) begin
        if (p < c) return ST_BELOW;
        kept[k] = 1'b1;
      end
    end
    if (kept != '0) begin
      if (pool_used >= PoolEntries || col_len[c] >= CountMax) return ST_FULL;
      if (col_len[c] == 0) col_start[c] = pool_used;
      pool_grp[pool_used] = grp;
      pool_mask[pool_used] = kept;
      pool_used++;
      col_len[c]++;
    end
    if (last) col_closed[c] = 1'b1;
    return ST_OK;
  endfunction

  function automatic logic stored_bit(input int unsigned x, input int unsigned y);
    int lo, hi, mid;
    int unsigned slot, want;
    want = y / 8;
    if (x >= MaxPatches || col_len[x] == 0) return 1'b0;
    lo = 0;
    hi = int'(col_len[x]) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      slot = (col_start[x] + mid) % PoolEntries;
      if (pool_grp[slot] < want) lo = mid + 1;
      else if (pool_grp[slot] > want) hi = mid - 1;
      else return pool_mask[slot][y % 8];
    end
    return 1'b0;
  endfunction

  function automatic answer_t matrix_answer(input logic [ModeW-1:0] mode,
      input logic [IdxW-1:0] a, input logic [IdxW-1:0] b, input logic [GroupW-1:0] grp,
      input logic [BitsW-1:0] raw, input logic last);
    answer_t ans;
    int unsigned lo_idx, hi_idx;
    ans.mode = mode;
    ans.a = a;
    ans.b = b;
    ans.visible = 1'b0;
    ans.status = ST_OK;
    case (mode)
      MODE_LOAD: ans.status = load_column_group(32'(a), 32'(grp), raw, last);
      MODE_QUERY: begin
        if (a == b) begin
          ans.visible = 1'b1;
        end else begin
          lo_idx = (a < b) ? 32'(a) : 32'(b);
          hi_idx = (a < b) ? 32'(b) : 32'(a);
          if (!patch_present(hi_idx)) ans.status = ST_RANGE;
          ans.visible = stored_bit(lo_idx, hi_idx);
        end
      end
      MODE_CLEAR: clear_matrix_copy();
      default: ;
    endcase
    return ans;
  endfunction

  function automatic int draw_wait(input bit on);
    return on ? int'($urandom_range(0, MaxWait)) : 0;
  endfunction

  task automatic send_word(input logic [ModeW-1:0] mode, input logic [IdxW-1:0] a,
      input logic [IdxW-1:0] b, input logic [GroupW-1:0] grp, input logic [BitsW-1:0] raw,
      input logic last);
    int gap;
    gap = draw_wait(in_idle_on);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    column_i     <= a;
    other_i      <= b;
    group_i      <= grp;
    bits_i       <= raw;
    last_group_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    pending_answers.push_back(matrix_answer(mode, a, b, grp, raw, last));
    words_sent++;
  endtask

  task automatic load_word(input int unsigned col, input int unsigned grp,
      input logic [BitsW-1:0] raw, input logic last);
    send_word(MODE_LOAD, IdxW'(col), '0, GroupW'(grp), raw, last);
  endtask

  task automatic query_pair(input int unsigned a, input int unsigned b);
    send_word(MODE_QUERY, IdxW'(a), IdxW'(b), '0, '0, 1'b0);
  endtask

  task automatic clear_word();
    send_word(MODE_CLEAR, '0, '0, '0, '0, 1'b0);
    filled_cols.delete();
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  task automatic set_patch_count(input int unsigned n);
    wait_idle();
    cfg_wdata_i <= NumW'(n);
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    patch_limit = n;
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_column_run(input int unsigned col);
    int unsigned grp, nxt, len;
    logic [BitsW-1:0] raw;
    logic last;
    len = $urandom_range(1, 8);
    grp = col / 8 + $urandom_range(0, 2);
    if (grp > 511) grp = 511;
    for (int i = 0; i < len && grp <= 511; i++) begin
      nxt = grp + $urandom_range(1, 4);
      raw = BitsW'($urandom_range(0, 255));
      if ($urandom_range(0, 19) != 0) begin
        for (int k = 0; k < BitsW; k++) if (grp * 8 + k < col) raw[k] = 1'b0;
      end
      last = (i == len - 1 || nxt > 511) && ($urandom_range(0, 7) != 0);
      send_word(MODE_LOAD, IdxW'(col), IdxW'($urandom_range(0, 4095)), GroupW'(grp),
                raw, last);
      grp = nxt;
    end
    filled_cols.push_back(col);
  endtask

  task automatic test_load_rules();
    load_word(0, 0, 8'hff, 1'b0);
    load_word(0, 511, 8'h80, 1'b1);
    load_word(0, 5, 8'h01, 1'b0);
    load_word(4095, 0, 8'h01, 1'b0);
    load_word(4095, 511, 8'h80, 1'b1);
    load_word(16, 1, 8'hff, 1'b0);
    load_word(16, 2, 8'h00, 1'b0);
    load_word(16, 3, 8'h5a, 1'b0);
    load_word(16, 4, 8'h00, 1'b1);
    load_word(3, 0, 8'h07, 1'b1);
    load_word(3, 0, 8'h08, 1'b1);
  endtask

  task automatic test_query_rules();
    query_pair(16, 29);
    query_pair(29, 16);
    query_pair(0, 7);
    query_pair(4095, 4095);
    query_pair(0, 4095);
    query_pair(5, 9);
    send_word(ModeUnused, 12'hfff, 12'hfff, 9'h1ff, 8'hff, 1'b1);
  endtask

  task automatic test_patch_count();
    set_patch_count(20);
    load_word(25, 3, 8'hff, 1'b0);
    // bits past the patch count are dropped before the diagonal check
    load_word(17, 2, 8'hf0, 1'b1);
    query_pair(16, 25);
    query_pair(4000, 4095);
    query_pair(3000, 3000);
    clear_word();
    query_pair(0, 7);
    set_patch_count(1);
    load_word(0, 0, 8'hff, 1'b1);
    query_pair(0, 1);
    query_pair(0, 0);
  endtask

  task automatic test_long_column();
    set_patch_count(NumReset);
    clear_word();
    for (int i = 0; i < 40; i++)
      load_word(5, 1 + i * 3, BitsW'($urandom_range(1, 255)), (i == 39));
    for (int i = 0; i < 30; i++) query_pair(5, $urandom_range(8, 960));
    query_pair(4, 100);
    query_pair(960, 5);
    clear_word();
  endtask

  task automatic test_random_traffic();
    int unsigned phase_limits[4];
    int start, r, tmp;
    logic [ModeW-1:0] mode;
    logic [IdxW-1:0] a, b;
    phase_limits[0] = MaxPatches;
    phase_limits[1] = $urandom_range(2, 4095);
    phase_limits[2] = 1;
    phase_limits[3] = $urandom_range(9, 200);
    foreach (phase_limits[p]) begin
      set_patch_count(phase_limits[p]);
      in_idle_on = 1'b1;
      out_idle_on = 1'b1;
      start = words_sent;
      while (words_sent - start < PhaseWords) begin
        if ($urandom_range(0, 11) == 0) in_idle_on = !in_idle_on;
        if ($urandom_range(0, 11) == 0) out_idle_on = !out_idle_on;
        r = $urandom_range(0, 99);
        if (r < 45) begin
          send_column_run($urandom_range(0, patch_limit - 1));
        end else if (r < 85) begin
          if (filled_cols.size() != 0 && $urandom_range(0, 3) != 0) begin
            a = IdxW'(filled_cols[$urandom_range(0, filled_cols.size() - 1)]);
            tmp = int'(a) + int'($urandom_range(0, 300));
            b = (tmp > 4095) ? 12'd4095 : IdxW'(tmp);
            if ($urandom_range(0, 1) == 1) {a, b} = {b, a};
          end else begin
            a = IdxW'($urandom_range(0, 4095));
            b = IdxW'($urandom_range(0, 4095));
          end
          send_word(MODE_QUERY, a, b, GroupW'($urandom_range(0, 511)),
                    BitsW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (r < 98) begin
          mode = ModeW'($urandom_range(0, 3));
          if (mode == MODE_CLEAR) mode = ModeUnused;
          send_word(mode, IdxW'($urandom_range(0, 4095)), IdxW'($urandom_range(0, 4095)),
                    GroupW'($urandom_range(0, 511)), BitsW'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end else begin
          clear_word();
        end
      end
    end
  endtask

  // result checker and output stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: visible %0b status %0d", visible_o, status_o);
      end else begin
        head_answer = pending_answers.pop_front();
        if (visible_o !== head_answer.visible || status_o !== head_answer.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch mode %0d a %0d b %0d: expected %0b/%0d, got %0b/%0d",
                     head_answer.mode, head_answer.a, head_answer.b, head_answer.visible,
                     head_answer.status, visible_o, status_o);
        end
      end
      ready_hold = draw_wait(out_idle_on);
      if (ready_hold > 0) out_ready_i <= 1'b0;
    end else if (ready_hold > 0 && out_valid_o) begin
      ready_hold--;
      if (ready_hold == 0) out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_answers.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_LOAD;
    column_i     = '0;
    other_i      = '0;
    group_i      = '0;
    bits_i       = '0;
    last_group_i = 1'b0;
    out_ready_i  = 1'b1;
    ready_hold   = 0;
    cycle_count  = 0;
    mismatches   = 0;
    words_sent   = 0;
    results_seen = 0;
    settings_used = 0;
    in_idle_on   = 1'b1;
    out_idle_on  = 1'b1;
    patch_limit  = NumReset;
    clear_matrix_copy();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_load_rules();
    test_query_rules();
    test_patch_count();
    test_long_column();
    test_random_traffic();

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d words, checked %0d results across %0d patch count settings",
             words_sent, results_seen, settings_used);
    $display("covered load and query rules, a deep column search and stalled random traffic");
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
